### sv/ale_pkg.sv
// Shared types and constants for the array list engine.
package ale_pkg;

	// Fixed field widths
	localparam int CNT_W      = 7;
	localparam int CMD_W      = 3;
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	// Capacity register: byte address and reset value
	localparam logic [APB_ADDR_W-1:0] REG_CAPACITY_ADDR = APB_ADDR_W'(0);
	localparam logic [CNT_W-1:0]      CAP_RESET         = CNT_W'(64);

	// Read value for a select on an empty list
	localparam int EMPTY_MARK = -999;

	// Request commands
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_SEARCH  = 3'd2,
		CMD_SELECT  = 3'd3,
		CMD_REPLACE = 3'd4
	} cmd_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic exec;
		logic load_out;
	} ctrl_cmd_t;

endpackage

### sv/ale_if.sv
// Request and response channel interfaces.
interface ale_req_if #(
	parameter int VALUE_WIDTH = 32
);
	import ale_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [CMD_W-1:0]              cmd;
	logic [CNT_W-1:0]              position;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, cmd, position, value, input ready);
	modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface ale_rsp_if #(
	parameter int VALUE_WIDTH = 32
);
	import ale_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic signed [VALUE_WIDTH-1:0] read_value;
	logic [CNT_W-1:0]              found_index;
	logic [CNT_W-1:0]              count;
	logic                          is_empty;
	logic                          is_full;

	modport source (output valid, ok, read_value, found_index, count, is_empty, is_full,
		input ready);
	modport sink   (input valid, ok, read_value, found_index, count, is_empty, is_full,
		output ready);
endinterface

### sv/ale_ctrl.sv
// Controller state machine: sequences request latch, execute and result load.
module ale_ctrl
	import ale_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output ctrl_cmd_t ctl
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// Result register can take a new result this cycle
	assign out_free = !out_valid_q || rsp_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = req_valid ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		req_ready    = 1'b0;
		ctl.exec     = 1'b0;
		ctl.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
			end
			ST_DONE: begin
				req_ready    = out_free;
				ctl.load_out = out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
		ctl.load_req = req_valid && req_ready;
	end

	// Response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

	// Execute is always followed by the result cycle
	a_exec_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_DONE)
		else $error("execute not followed by result cycle");

	// No new request is latched while one is executing
	a_no_req_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_req |-> state_q != ST_EXEC)
		else $error("request latched during execute");

endmodule

### sv/ale_dp.sv
// Datapath: shifting entry cells, search compare, select read and result registers.
module ale_dp
	import ale_pkg::*;
#(
	parameter int MAX_ENTRIES = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctrl_cmd_t                     ctl,
	input  logic [CMD_W-1:0]              req_cmd,
	input  logic [CNT_W-1:0]              req_position,
	input  logic signed [VALUE_WIDTH-1:0] req_value,
	input  logic [CNT_W-1:0]              capacity,
	output logic                          rsp_ok,
	output logic signed [VALUE_WIDTH-1:0] rsp_read_value,
	output logic [CNT_W-1:0]              rsp_found_index,
	output logic [CNT_W-1:0]              rsp_count,
	output logic                          rsp_is_empty,
	output logic                          rsp_is_full
);

	localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CMP_W   = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
	localparam int CAP_LIM = (MAX_ENTRIES < 127) ? MAX_ENTRIES : 127;

	// Latched request
	logic [CMD_W-1:0]              cmd_q;
	logic [CNT_W-1:0]              pos_q;
	logic signed [VALUE_WIDTH-1:0] val_q;

	// List state
	logic signed [VALUE_WIDTH-1:0] cell_q [MAX_ENTRIES];
	logic [CNT_W-1:0]              count_q;

	// Execute stage results
	logic                          ok_s1;
	logic signed [VALUE_WIDTH-1:0] rd_s1;
	logic                          srch_s1;
	logic [MAX_ENTRIES-1:0]        match_s1;

	// Output stage
	logic                          ok_s2;
	logic signed [VALUE_WIDTH-1:0] rd_s2;
	logic [CNT_W-1:0]              fidx_s2;
	logic [CNT_W-1:0]              cnt_s2;
	logic                          empty_s2;
	logic                          full_s2;

	logic [CNT_W-1:0]              eff_cap;
	logic [CMP_W-1:0]              pos_w;
	logic [CMP_W-1:0]              cnt_w;
	logic [CMP_W-1:0]              rd_idx;
	logic                          ins_ok;
	logic                          rem_ok;
	logic                          do_ins;
	logic                          do_rem;
	logic                          do_rep;
	logic                          op_ok;
	logic signed [VALUE_WIDTH-1:0] rd_val;
	logic [CNT_W-1:0]              first_hit;
	logic [MAX_ENTRIES-1:0]        match_d;

	// Request latch
	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			cmd_q <= req_cmd;
			pos_q <= req_position;
			val_q <= req_value;
		end
	end

	// Capacity clamped to the store depth
	assign eff_cap = (capacity > CNT_W'(CAP_LIM)) ? CNT_W'(CAP_LIM) : capacity;
	assign pos_w   = CMP_W'(pos_q);
	assign cnt_w   = CMP_W'(count_q);

	// Legality checks
	assign ins_ok = (count_q < eff_cap) && (pos_q <= count_q);
	assign rem_ok = (count_q != '0) && (pos_q < count_q);

	// Command decode
	always_comb begin
		do_ins = 1'b0;
		do_rem = 1'b0;
		do_rep = 1'b0;
		unique case (cmd_t'(cmd_q))
			CMD_INSERT:  do_ins = ins_ok;
			CMD_REMOVE:  do_rem = rem_ok;
			CMD_REPLACE: do_rep = rem_ok;
			default:     ;
		endcase
	end
	assign op_ok = do_ins || do_rem || do_rep;

	// Entry cells: each loads its left neighbor, right neighbor or the request value
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
		logic signed [VALUE_WIDTH-1:0] left_v;
		logic signed [VALUE_WIDTH-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_left
			assign left_v = cell_q[i-1];
		end
		if (i == MAX_ENTRIES - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_right
			assign right_v = cell_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (ctl.exec) begin
				if (do_ins) begin
					if (IDX == pos_w) begin
						cell_q[i] <= val_q;
					end else if (IDX > pos_w && IDX <= cnt_w) begin
						cell_q[i] <= left_v;
					end
				end else if (do_rem) begin
					if (IDX >= pos_w && (IDX + CMP_W'(1)) < cnt_w) begin
						cell_q[i] <= right_v;
					end
				end else if (do_rep && IDX == pos_w) begin
					cell_q[i] <= val_q;
				end
			end
		end

		// Search compare over live entries
		assign match_d[i] = (cell_q[i] == val_q) && (IDX < cnt_w);
	end

	// Select read: past the end reads the last entry
	assign rd_idx = (pos_w >= cnt_w) ? (cnt_w - CMP_W'(1)) : pos_w;
	always_comb begin
		rd_val = '0;
		if (cmd_t'(cmd_q) == CMD_SELECT) begin
			rd_val = (count_q == '0) ? VALUE_WIDTH'(EMPTY_MARK) : cell_q[rd_idx[IDX_W-1:0]];
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.exec) begin
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Execute stage registers
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			ok_s1    <= op_ok;
			rd_s1    <= rd_val;
			srch_s1  <= (cmd_t'(cmd_q) == CMD_SEARCH);
			match_s1 <= match_d;
		end
	end

	// First match, or the count when absent
	always_comb begin
		first_hit = count_q;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (match_s1[i]) first_hit = CNT_W'(i);
		end
	end

	// Output registers
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			ok_s2    <= ok_s1;
			rd_s2    <= rd_s1;
			fidx_s2  <= srch_s1 ? first_hit : '0;
			cnt_s2   <= count_q;
			empty_s2 <= (count_q == '0);
			full_s2  <= (count_q >= eff_cap);
		end
	end

	assign rsp_ok          = ok_s2;
	assign rsp_read_value  = rd_s2;
	assign rsp_found_index = fidx_s2;
	assign rsp_count       = cnt_s2;
	assign rsp_is_empty    = empty_s2;
	assign rsp_is_full     = full_s2;

	// Count never passes the clamped store limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAP_LIM))
		else $error("entry count beyond store limit");

	// Count moves only in the execute cycle
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.exec |=> $stable(count_q))
		else $error("entry count changed outside execute");

endmodule

### sv/array_list_engine.sv
// Array list engine top level: channels, capacity register, controller and datapath.
//
//  channel   dir  handshake        payload
//  req       in   valid/ready      cmd, position, value
//  rsp       out  valid/ready      ok, read_value, found_index, count, is_empty, is_full
//  apb       in   psel/penable     paddr, pwrite, pwdata, prdata (pready tied high)
//
// Each request runs an execute state on the cell chain, then a result state for the
// match priority encoder; a new request is taken in the idle or result state, never during execute.
// Reset clears the entry count and sets capacity to 64; entries are not cleared.
// A finished result waits in the output register; the next request is still taken
// and executed, and its result cycle holds until the output register frees.
module array_list_engine
	import ale_pkg::*;
#(
	parameter int MAX_ENTRIES = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	ale_req_if.sink                req,
	ale_rsp_if.source              rsp,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	ctrl_cmd_t        ctl;
	logic [CNT_W-1:0] cap_q;
	logic             cfg_wr;

	// Capacity register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr && paddr == REG_CAPACITY_ADDR) begin
			cap_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr == REG_CAPACITY_ADDR) ? APB_DATA_W'(cap_q) : '0;

	// Controller
	ale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl)
	);

	// Datapath
	ale_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.req_cmd         (req.cmd),
		.req_position    (req.position),
		.req_value       (req.value),
		.capacity        (cap_q),
		.rsp_ok          (rsp.ok),
		.rsp_read_value  (rsp.read_value),
		.rsp_found_index (rsp.found_index),
		.rsp_count       (rsp.count),
		.rsp_is_empty    (rsp.is_empty),
		.rsp_is_full     (rsp.is_full)
	);

endmodule
